// ===== rtl/u8dec_pkg.sv =====
package u8dec_pkg;

    // result status codes
    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;
    localparam logic [1:0] ST_ILLEGAL = 2'd3;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned LEN_W = 3;

    // byte classification masks
    localparam logic [7:0] MASK_B7   = 8'b1000_0000;
    localparam logic [7:0] MASK_TOP2 = 8'b1100_0000;
    localparam logic [7:0] MASK_TOP3 = 8'b1110_0000;
    localparam logic [7:0] MASK_TOP4 = 8'b1111_0000;
    localparam logic [7:0] MASK_TOP5 = 8'b1111_1000;
    localparam logic [7:0] MASK_LOW6 = 8'b0011_1111;

    // partial sequence kept between bytes
    typedef struct packed {
        logic [1:0]       bytes_held;
        logic [LEN_W-1:0] expected_len;
        logic [CP_W-1:0]  partial_value;
    } seq_state_t;

    // one result item
    typedef struct packed {
        logic [1:0]       status;
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
    } dec_result_t;

endpackage

// ===== rtl/utf8_byte_stream_decoder.sv =====
// UTF-8 byte stream decoder.
// Input channel: in_valid / in_ready with in_byte, one raw byte per transfer.
// Output channel: out_valid / out_ready with status, code_point, seq_length.
// Every input byte produces exactly one result: pending while a multi-byte
// sequence is open, done with the code point and length when it closes, null
// when the decoded value is zero, illegal for a bad lead or continuation byte
// (the byte is consumed and the open sequence dropped).
// The result is registered and shows on the output in the cycle after the
// input transfer.
// Throughput: one byte per cycle while results drain; the per-byte decode is
// a single mask and shift stage between the input and the result register.
// The block takes a new byte while the result register is empty or being
// drained in the same cycle; a stalled receiver holds the result and pauses
// the input through in_ready.
// Reset (rst_n low, asynchronous) drops any partial sequence and empties the
// result register.
module utf8_byte_stream_decoder
    import u8dec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [CP_W-1:0]     code_point,
    output logic [LEN_W-1:0]    seq_length
);

    seq_state_t  state_reg;
    seq_state_t  state_next;
    dec_result_t result_next;
    dec_result_t result_reg;
    logic        out_valid_reg;
    logic        in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // per-byte decode
    u8dec_step u_step (
        .in_byte    (in_byte),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = result_reg.status;
    assign code_point = result_reg.code_point;
    assign seq_length = result_reg.seq_length;

    // length is reported only for a completed character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((result_reg.status == ST_DONE) == (result_reg.seq_length != '0)))
        else $error("seq_length does not match status");

    // a completed character never carries a zero code point
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.status == ST_DONE) |-> (result_reg.code_point != '0))
        else $error("done status with zero code point");

    // code point is zero for any other status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.status != ST_DONE) |-> (result_reg.code_point == '0))
        else $error("code point set without done status");

    // an open sequence always has a multi-byte length beyond the bytes held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bytes_held != 2'd0) |->
            (state_reg.expected_len >= LEN_W'(2) && state_reg.expected_len <= LEN_W'(4)
             && {1'b0, state_reg.bytes_held} < state_reg.expected_len))
        else $error("inconsistent partial sequence state");

    // a pending result leaves a sequence open
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && result_next.status == ST_PENDING) |=> (state_reg.bytes_held != 2'd0))
        else $error("pending result without open sequence");

endmodule

// ===== rtl/u8dec_step.sv =====
module u8dec_step
    import u8dec_pkg::*;
(
    input  logic [7:0]  in_byte,
    input  seq_state_t  state,
    output seq_state_t  state_next,
    output dec_result_t result
);

    logic [LEN_W-1:0] lead_len;
    logic [CP_W-1:0]  lead_bits;
    logic [CP_W-1:0]  cont_value;
    logic [1:0]       held_inc;
    logic             cont_done;

    // lead byte length and kept payload bits
    always_comb
    begin
        lead_len  = '0;
        lead_bits = '0;
        priority if ((in_byte & MASK_B7) == 8'h00)
        begin
            lead_len  = LEN_W'(1);
            lead_bits = CP_W'(in_byte);
        end
        else if ((in_byte & MASK_TOP3) == MASK_TOP2)
        begin
            lead_len  = LEN_W'(2);
            lead_bits = CP_W'(in_byte[4:0]);
        end
        else if ((in_byte & MASK_TOP4) == MASK_TOP3)
        begin
            lead_len  = LEN_W'(3);
            lead_bits = CP_W'(in_byte[3:0]);
        end
        else if ((in_byte & MASK_TOP5) == MASK_TOP4)
        begin
            lead_len  = LEN_W'(4);
            lead_bits = CP_W'(in_byte[2:0]);
        end
        else
        begin
            // continuation byte or 0xF8 and above cannot start a sequence
            lead_len  = '0;
            lead_bits = '0;
        end
    end

    // continuation byte appends six bits
    assign cont_value = {state.partial_value[CP_W-7:0], in_byte[5:0] & MASK_LOW6[5:0]};
    assign held_inc   = state.bytes_held + 2'd1;
    assign cont_done  = (held_inc == 2'd0) || ({1'b0, held_inc} >= state.expected_len);

    // next state and result
    always_comb
    begin
        state_next = '0;
        result     = '0;
        if (state.bytes_held == 2'd0)
        begin
            if (lead_len == '0)
            begin
                result.status = ST_ILLEGAL;
            end
            else if (lead_len == LEN_W'(1))
            begin
                if (lead_bits == '0)
                begin
                    result.status = ST_NULL;
                end
                else
                begin
                    result.status     = ST_DONE;
                    result.code_point = lead_bits;
                    result.seq_length = lead_len;
                end
            end
            else
            begin
                state_next.bytes_held    = 2'd1;
                state_next.expected_len  = lead_len;
                state_next.partial_value = lead_bits;
                result.status            = ST_PENDING;
            end
        end
        else if ((in_byte & MASK_TOP2) != MASK_B7)
        begin
            result.status = ST_ILLEGAL;
        end
        else if (cont_done)
        begin
            if (cont_value == '0)
            begin
                result.status = ST_NULL;
            end
            else
            begin
                result.status     = ST_DONE;
                result.code_point = cont_value;
                result.seq_length = state.expected_len;
            end
        end
        else
        begin
            state_next.bytes_held    = held_inc;
            state_next.expected_len  = state.expected_len;
            state_next.partial_value = cont_value;
            result.status            = ST_PENDING;
        end
    end

endmodule

// ===== tb/utf8_decode_checker.sv =====
`timescale 1ns / 100ps

module utf8_decode_checker
    import u8dec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [1:0]       status,
    input  logic [CP_W-1:0]  code_point,
    input  logic [LEN_W-1:0] seq_length,
    output int               mismatches,
    output int               owed,
    output int               bytes_taken,
    output int               chars_decoded,
    output int               nulls_seen,
    output int               illegals_seen
);

    // decoder state mirrored from the byte stream
    logic [1:0]       held_cnt = '0;
    logic [LEN_W-1:0] seq_len  = '0;
    logic [CP_W-1:0]  acc      = '0;

    dec_result_t decoded_queue[$];
    int          fail_total = 0;

    assign mismatches = fail_total;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_total++;
    endtask

    // sequence ends: drop the state, zero value turns into a null character
    function automatic dec_result_t close_sequence(input logic [CP_W-1:0] value,
                                                   input logic [LEN_W-1:0] len);
        dec_result_t r;
        r        = '0;
        held_cnt = '0;
        seq_len  = '0;
        acc      = '0;
        if (value == '0)
        begin
            r.status = ST_NULL;
        end
        else
        begin
            r.status     = ST_DONE;
            r.code_point = value;
            r.seq_length = len;
        end
        return r;
    endfunction

    // next result for one byte, updating the mirrored state
    function automatic dec_result_t decode_byte(input logic [7:0] b);
        dec_result_t      r;
        logic [LEN_W-1:0] len;
        logic [7:0]       payload;
        r = '0;
        if (held_cnt == 2'd0)
        begin
            // lead byte sets the sequence length
            if ((b & MASK_B7) == 8'h00)
                len = 3'd1;
            else if ((b & MASK_TOP3) == MASK_TOP2)
                len = 3'd2;
            else if ((b & MASK_TOP4) == MASK_TOP3)
                len = 3'd3;
            else if ((b & MASK_TOP5) == MASK_TOP4)
                len = 3'd4;
            else
                len = 3'd0;

            if (len == 3'd0)
            begin
                held_cnt = '0;
                seq_len  = '0;
                acc      = '0;
                r.status = ST_ILLEGAL;
            end
            else if (len == 3'd1)
            begin
                r = close_sequence({13'd0, b}, len);
            end
            else
            begin
                payload  = b & (8'hFF >> (len + 3'd1));
                acc      = {13'd0, payload};
                seq_len  = len;
                held_cnt = 2'd1;
                r.status = ST_PENDING;
            end
        end
        else if ((b & MASK_TOP2) != MASK_B7)
        begin
            // bad continuation is consumed and the sequence dropped
            held_cnt = '0;
            seq_len  = '0;
            acc      = '0;
            r.status = ST_ILLEGAL;
        end
        else
        begin
            payload  = b & MASK_LOW6;
            acc      = {acc[CP_W-7:0], payload[5:0]};
            held_cnt = held_cnt + 2'd1;
            if (held_cnt == 2'd0 || {1'b0, held_cnt} >= seq_len)
                r = close_sequence(acc, seq_len);
            else
                r.status = ST_PENDING;
        end
        return r;
    endfunction

    // watch both channels: compare on result transfer, predict on byte transfer
    always @(posedge clk or negedge rst_n)
    begin
        dec_result_t want;
        if (!rst_n)
        begin
            held_cnt = '0;
            seq_len  = '0;
            acc      = '0;
            decoded_queue.delete();
            owed          <= 0;
            bytes_taken   <= 0;
            chars_decoded <= 0;
            nulls_seen    <= 0;
            illegals_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_queue.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result status=%0d cp=%0h len=%0d",
                                              status, code_point, seq_length));
                end
                else
                begin
                    want = decoded_queue.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d exp %0d",
                                                  status, want.status));
                    if (code_point !== want.code_point)
                        report_mismatch($sformatf("code_point got %0h exp %0h",
                                                  code_point, want.code_point));
                    if (seq_length !== want.seq_length)
                        report_mismatch($sformatf("seq_length got %0d exp %0d",
                                                  seq_length, want.seq_length));
                    case (want.status)
                        ST_DONE:    chars_decoded <= chars_decoded + 1;
                        ST_NULL:    nulls_seen    <= nulls_seen + 1;
                        ST_ILLEGAL: illegals_seen <= illegals_seen + 1;
                        default:    ;
                    endcase
                end
            end
            if (in_valid && in_ready)
            begin
                decoded_queue.push_back(decode_byte(in_byte));
                bytes_taken <= bytes_taken + 1;
            end
            owed <= decoded_queue.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb
    import u8dec_pkg::*;
();

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [7:0]       in_byte   = 8'h00;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       status;
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;

    int mismatches;
    int owed;
    int bytes_taken;
    int chars_decoded;
    int nulls_seen;
    int illegals_seen;

    int tx_idle_pct = 28;
    int rx_idle_pct = 53;
    int bytes_sent  = 0;

    logic [7:0] directed_seq [0:24];

    utf8_byte_stream_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .code_point (code_point),
        .seq_length (seq_length)
    );

    utf8_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .code_point    (code_point),
        .seq_length    (seq_length),
        .mismatches    (mismatches),
        .owed          (owed),
        .bytes_taken   (bytes_taken),
        .chars_decoded (chars_decoded),
        .nulls_seen    (nulls_seen),
        .illegals_seen (illegals_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver stalls at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one byte transfer, with a random idle gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    // mostly well-formed sequences, some cut short, some raw noise
    task automatic send_random_sequence();
        int         kind;
        int         len;
        int         n_cont;
        logic [31:0] r;
        logic [7:0] lead;
        kind = $urandom_range(99);
        r    = $urandom;
        if (kind >= 90)
        begin
            send_byte(r[7:0]);
        end
        else
        begin
            len = (kind < 80) ? $urandom_range(1, 4) : $urandom_range(2, 4);
            case (len)
                1:       lead = {1'b0, r[6:0]};
                2:       lead = {3'b110, r[4:0]};
                3:       lead = {4'b1110, r[3:0]};
                default: lead = {5'b11110, r[2:0]};
            endcase
            n_cont = (kind < 80) ? len - 1 : $urandom_range(0, len - 2);
            send_byte(lead);
            repeat (n_cont)
            begin
                r = $urandom;
                send_byte({2'b10, r[5:0]});
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int target;
        directed_seq = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                         8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF,
                         8'hBF, 8'hC0, 8'h80, 8'h80, 8'hFF, 8'hF8, 8'hC3,
                         8'h41, 8'hE0, 8'hC0, 8'h80};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, every length, null forms, bad leads and bad continuations
        for (int i = 0; i < 25; i++)
            send_byte(directed_seq[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 53;
                end
                1:
                begin
                    tx_idle_pct = 53;
                    rx_idle_pct = 28;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            target = bytes_sent + 330;
            while (bytes_sent < target)
                send_random_sequence();
        end
        in_valid <= 1'b0;

        // drain outstanding results
        do
            @(posedge clk);
        while (owed != 0);
        repeat (5) @(posedge clk);

        $display("Covered %0d bytes under three pacing modes: %0d characters, %0d nulls,",
                 bytes_taken, chars_decoded, nulls_seen);
        $display("%0d illegal bytes, %0d mismatches", illegals_seen, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout waiting for the decoder");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/u8dec_pkg.sv
rtl/u8dec_step.sv
rtl/utf8_byte_stream_decoder.sv
tb/utf8_decode_checker.sv
tb/tb.sv
